// File: design/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and fixed widths of the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int SAMPLE_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_INIT,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: design/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Running mean over the last WINDOW signed samples (fewer until the window fills), bit-serial divide.
// ----------------------------------------------------------------------------
// flow: a request passes ST_LOAD, ST_ADD, ST_INIT, ST_DIV and ST_FIN; the restoring
//   divider in ST_DIV retires one quotient bit per cycle
// requests: one at a time, accepted only in ST_IDLE; the result register lets the
//   next request enter while a result waits
// reset: clears state, write pointer, fill count, running sum and result valid;
//   the sample ring holds no reset value and is read only after it was written
module moving_average_filter #(
  parameter int WINDOW = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] sample,
  output logic                               average_valid,
  input  logic                               average_ready,
  output logic signed [maf_pkg::SAMPLE_W-1:0] average
);

  import maf_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int BIT_W = $clog2(SUM_W + 1);

  state_t state, state_next;

  logic signed [SAMPLE_W-1:0] sample_reg;
  logic [PTR_W-1:0]           write_pointer;
  logic [CNT_W-1:0]           fill_count;
  logic signed [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]           divisor;
  logic [SUM_W-1:0]           quo;
  logic [CNT_W-1:0]           rem;
  logic                       neg;
  logic [BIT_W-1:0]           bit_cnt;

  logic                       ring_we;
  logic [SAMPLE_W-1:0]        ring_rdata;
  logic                       full;
  logic                       accept;
  logic                       load_out;
  logic [CNT_W:0]             rem_sh;
  logic                       rem_ge;
  logic [SAMPLE_W-1:0]        quo_neg;

  assign full    = (fill_count == CNT_W'(WINDOW));
  assign accept  = sample_valid && sample_ready;
  assign rem_sh  = {rem, quo[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});
  assign quo_neg = -quo[SAMPLE_W-1:0];

  maf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .addr (write_pointer),
    .wdata(sample_reg),
    .rdata(ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    ring_we      = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_ADD;
      ST_ADD: begin
        ring_we    = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (bit_cnt == BIT_W'(1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the quotient until the result register is free
        if (!average_valid || average_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
      average_valid <= 1'b0;
    end else begin
      if (load_out) begin
        average_valid <= 1'b1;
      end else if (average_ready) begin
        average_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          // oldest sample leaves the sum once the ring is full
          if (full) begin
            running_sum <= running_sum - SUM_W'($signed(ring_rdata));
            divisor     <= CNT_W'(WINDOW);
          end else begin
            divisor <= fill_count + CNT_W'(1);
          end
        end
        ST_ADD: begin
          running_sum <= running_sum + SUM_W'(sample_reg);
          if (!full) begin
            fill_count <= fill_count + CNT_W'(1);
          end
          if (write_pointer == PTR_W'(WINDOW - 1)) begin
            write_pointer <= '0;
          end else begin
            write_pointer <= write_pointer + PTR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample;
    end
    case (state)
      ST_INIT: begin
        neg     <= running_sum[SUM_W-1];
        quo     <= running_sum[SUM_W-1] ? -running_sum : running_sum;
        rem     <= '0;
        bit_cnt <= BIT_W'(SUM_W);
      end
      ST_DIV: begin
        // one restoring step per cycle, quotient bits shift in at the bottom
        if (rem_ge) begin
          rem <= CNT_W'(rem_sh - {1'b0, divisor});
        end else begin
          rem <= rem_sh[CNT_W-1:0];
        end
        quo     <= {quo[SUM_W-2:0], rem_ge};
        bit_cnt <= bit_cnt - BIT_W'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      average <= neg ? quo_neg : quo[SAMPLE_W-1:0];
    end
  end

endmodule

// File: design/maf_ram.sv
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
